// File: rtl/sacl_pkg.sv
// Package for the set-associative cache tag unit.
// Geometry constants, field widths and the request type passed from the
// front queue to the back end. No dependencies.
package sacl_pkg;

  localparam int NUM_SETS       = 4;
  localparam int NUM_WAYS       = 4;
  localparam int TAG_BITS       = 26;
  localparam int LINE_SHIFT     = 4;
  localparam int ADDR_BITS      = 32;
  localparam int WAY_FIELD_BITS = 2;

  localparam int SET_BITS = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WAY_BITS = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;

  // request queue between front and back; depth must be a power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [SET_BITS-1:0] set_idx;
    logic [TAG_BITS-1:0] tag;
  } req_t;

endpackage

// File: rtl/sacl_if.sv
// Valid/ready channel interfaces for the cache tag unit.
// Depends on sacl_pkg for the field widths.
interface sacl_in_if;
  logic                           valid;
  logic                           ready;
  logic [sacl_pkg::ADDR_BITS-1:0] address;

  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);
endinterface

interface sacl_out_if;
  logic                                valid;
  logic                                ready;
  logic                                hit;
  logic [sacl_pkg::WAY_FIELD_BITS-1:0] way;
  logic                                evicted;

  modport source (output valid, output hit, output way, output evicted, input ready);
  modport sink   (input valid, input hit, input way, input evicted, output ready);
endinterface

// File: rtl/sacl_front.sv
// Front end: accepts addresses, splits them into set index and tag and
// queues the requests for the back end. Depends on sacl_pkg, sacl_in_if.
module sacl_front (
  input  logic            clk,
  input  logic            rst_n,
  sacl_in_if.sink         in_ch,
  output logic            q_valid,
  input  logic            q_ready,
  output sacl_pkg::req_t  q_req
);
  import sacl_pkg::*;

  req_t                 queue_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                 push, pop;
  logic [ADDR_BITS-1:0] line_addr;
  logic [ADDR_BITS-1:0] tag_full;
  req_t                 req_in;

  always_comb begin
    line_addr      = in_ch.address >> LINE_SHIFT;
    tag_full       = line_addr >> SET_BITS;
    req_in.set_idx = line_addr[SET_BITS-1:0];
    req_in.tag     = tag_full[TAG_BITS-1:0];
  end

  assign in_ch.ready = (cnt_r != QCNT_BITS'(QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != '0);
  assign pop         = q_valid && q_ready;
  assign q_req       = queue_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= req_in;
    end
  end

endmodule

// File: rtl/sacl_back.sv
// Back end: tag compare, fill/replace and true-LRU update of one set per cycle
// when not stalled, with a registered result stage. Depends on sacl_pkg, sacl_out_if.
module sacl_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  output logic            q_ready,
  input  sacl_pkg::req_t  q_req,
  sacl_out_if.source      out_ch
);
  import sacl_pkg::*;

  logic [TAG_BITS-1:0] tag_r   [NUM_SETS][NUM_WAYS];
  logic                valid_r [NUM_SETS][NUM_WAYS];
  // recency list per set, entry 0 is least recently used
  logic [WAY_BITS-1:0] order_r [NUM_SETS][NUM_WAYS];

  logic                      out_valid_r, out_valid_nxt;
  logic                      hit_r;
  logic [WAY_FIELD_BITS-1:0] way_r;
  logic                      evicted_r;

  logic                take;
  logic                hit, has_free, evict;
  logic [WAY_BITS-1:0] hit_way, free_way, sel_way, pos;
  logic [WAY_BITS-1:0] order_nxt [NUM_WAYS];
  logic [31:0]         way_wide;

  assign q_ready = !out_valid_r || out_ch.ready;
  assign take    = q_valid && q_ready;

  always_comb begin
    hit      = 1'b0;
    hit_way  = '0;
    has_free = 1'b0;
    free_way = '0;
    // descending scan so the lowest way wins
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (valid_r[q_req.set_idx][w] && (tag_r[q_req.set_idx][w] == q_req.tag)) begin
        hit     = 1'b1;
        hit_way = WAY_BITS'(w);
      end
      if (!valid_r[q_req.set_idx][w]) begin
        has_free = 1'b1;
        free_way = WAY_BITS'(w);
      end
    end
    evict = !hit && !has_free;
    if (hit) begin
      sel_way = hit_way;
    end else if (has_free) begin
      sel_way = free_way;
    end else begin
      sel_way = order_r[q_req.set_idx][0];
    end

    pos = '0;
    for (int i = NUM_WAYS - 1; i >= 0; i--) begin
      if (order_r[q_req.set_idx][i] == sel_way) begin
        pos = WAY_BITS'(i);
      end
    end
    for (int i = 0; i < NUM_WAYS - 1; i++) begin
      if (WAY_BITS'(i) >= pos) begin
        order_nxt[i] = order_r[q_req.set_idx][i+1];
      end else begin
        order_nxt[i] = order_r[q_req.set_idx][i];
      end
    end
    order_nxt[NUM_WAYS-1] = sel_way;
    way_wide = 32'(sel_way);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int s = 0; s < NUM_SETS; s++) begin
        for (int w = 0; w < NUM_WAYS; w++) begin
          valid_r[s][w] <= 1'b0;
          order_r[s][w] <= WAY_BITS'(w);
        end
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        order_r[q_req.set_idx] <= order_nxt;
        if (!hit) begin
          valid_r[q_req.set_idx][sel_way] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (!hit) begin
        tag_r[q_req.set_idx][sel_way] <= q_req.tag;
      end
      hit_r     <= hit;
      way_r     <= way_wide[WAY_FIELD_BITS-1:0];
      evicted_r <= evict;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.hit     = hit_r;
  assign out_ch.way     = way_r;
  assign out_ch.evicted = evicted_r;

endmodule

// File: rtl/set_assoc_cache_lru_tags_unit.sv
// Four-way set-associative cache tag unit with true LRU replacement. Each
// address transaction returns one result: hit, the way hit, filled or
// replaced, and whether a valid tag was evicted. The unit sustains one
// transaction per cycle while the consumer keeps accepting results. An
// accepted address is registered in the request queue and its result in
// the result register. The back end reads, compares and updates one set's
// tags, valid bits and recency list in the same cycle. A two-entry request
// queue holds up to two addresses while the result register waits on the
// consumer. Once the queue is full and the result is stalled, the input
// stalls. No clearing pass is needed after reset. Depends on sacl_pkg,
// sacl_if, sacl_front, sacl_back.
module set_assoc_cache_lru_tags_unit (
  input  logic       clk,
  input  logic       rst_n,
  sacl_in_if.sink    in_ch,
  sacl_out_if.source out_ch
);
  import sacl_pkg::*;

  logic q_valid;
  logic q_ready;
  req_t q_req;

  sacl_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_req   (q_req)
  );

  sacl_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_req   (q_req),
    .out_ch  (out_ch)
  );

endmodule

// File: rtl/sacl_checker.sv
// Port-level checks for the cache tag unit, bound to the top level.
// Depends on sacl_pkg for the queue depth.
module sacl_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_hit,
  input logic out_evicted
);
  import sacl_pkg::*;

  localparam int PEND_BITS = $clog2(QUEUE_DEPTH + 3);

  logic [PEND_BITS-1:0] pend_r;
  logic                 in_xfer, out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // transactions accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (in_xfer && !out_xfer) begin
      pend_r <= pend_r + 1'b1;
    end else if (out_xfer && !in_xfer) begin
      pend_r <= pend_r - 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_no_hit_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_evicted))
    else $error("hit and evicted both set");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != '0)
    else $error("result without an accepted address");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= PEND_BITS'(QUEUE_DEPTH + 1))
    else $error("more transactions in flight than storage");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind set_assoc_cache_lru_tags_unit sacl_checker u_sacl_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_hit     (out_ch.hit),
  .out_evicted (out_ch.evicted)
);

// File: tb/sv/tb_set_assoc_cache_lru_tags_unit.sv
// Self-checking testbench for set_assoc_cache_lru_tags_unit: directed address table,
// then random traffic, mostly from a small tag pool, each result checked against the
// LRU tag model or a typed row. Depends on sacl_pkg, sacl_if and the RTL of the unit.
module tb_set_assoc_cache_lru_tags_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import sacl_pkg::*;

  localparam int RANDOM_ITEMS = 1430;
  localparam int QUIET_ITEMS  = 200;
  localparam int STALL_LIMIT  = 1000;
  localparam int LONG_HOLD    = 40;
  localparam int TAG_POOL     = 8;
  localparam int DIR_ROWS     = 22;

  typedef struct packed {
    logic                      hit;
    logic [WAY_FIELD_BITS-1:0] way;
    logic                      evicted;
  } lookup_res_t;

  // typed = 1: hit/way/evicted are the literal expectation; else the model decides
  typedef struct packed {
    logic [ADDR_BITS-1:0]      addr;
    logic                      typed;
    logic                      hit;
    logic [WAY_FIELD_BITS-1:0] way;
    logic                      evicted;
  } dir_row_t;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{32'h0000_0000, 1'b1, 1'b0, 2'd0, 1'b0},  // empty set fills way 0
    '{32'h0000_0040, 1'b1, 1'b0, 2'd1, 1'b0},
    '{32'h0000_0080, 1'b1, 1'b0, 2'd2, 1'b0},
    '{32'h0000_00C0, 1'b1, 1'b0, 2'd3, 1'b0},
    '{32'h0000_000F, 1'b1, 1'b1, 2'd0, 1'b0},  // offset bits ignored
    '{32'h0000_0100, 1'b1, 1'b0, 2'd1, 1'b1},  // full set, way 1 is LRU
    '{32'h0000_0040, 1'b0, 1'b0, 2'd0, 1'b0},
    '{32'hFFFF_FFFF, 1'b1, 1'b0, 2'd0, 1'b0},
    '{32'hFFFF_FFF0, 1'b1, 1'b1, 2'd0, 1'b0},
    '{32'hFFFF_FFCF, 1'b0, 1'b0, 2'd0, 1'b0},
    '{32'h0000_0030, 1'b1, 1'b0, 2'd1, 1'b0},
    '{32'h0000_0010, 1'b1, 1'b0, 2'd0, 1'b0},
    '{32'h0000_0020, 1'b1, 1'b0, 2'd0, 1'b0},
    '{32'h8000_0000, 1'b0, 1'b0, 2'd0, 1'b0},
    '{32'hAAAA_AAAA, 1'b0, 1'b0, 2'd0, 1'b0},
    '{32'h5555_5555, 1'b0, 1'b0, 2'd0, 1'b0},
    '{32'h0000_0030, 1'b1, 1'b1, 2'd1, 1'b0},
    '{32'h0000_0050, 1'b0, 1'b0, 2'd0, 1'b0},
    '{32'h0000_0090, 1'b0, 1'b0, 2'd0, 1'b0},
    '{32'h0000_00D0, 1'b0, 1'b0, 2'd0, 1'b0},
    '{32'h0000_0110, 1'b0, 1'b0, 2'd0, 1'b0},
    '{32'h0000_0110, 1'b0, 1'b0, 2'd0, 1'b0}
  };

  logic clk = 1'b0;
  logic rst_n;

  sacl_in_if  in_bus ();
  sacl_out_if out_bus ();

  set_assoc_cache_lru_tags_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  always #5 clk = ~clk;

  // tag store model
  logic [TAG_BITS-1:0] tag_mem    [NUM_SETS][NUM_WAYS];
  logic                line_valid [NUM_SETS][NUM_WAYS];
  logic [WAY_BITS-1:0] lru_order  [NUM_SETS][NUM_WAYS];  // least recent first

  lookup_res_t pending_lookups [$];
  int          mismatch_count = 0;
  int          stall_cycles = 0;
  bit          quiet_phase = 1'b0;
  bit          long_hold_req = 1'b0;

  function automatic lookup_res_t lru_lookup(input logic [ADDR_BITS-1:0] addr);
    logic [ADDR_BITS-1:0] line;
    logic [SET_BITS-1:0]  set_idx;
    logic [TAG_BITS-1:0]  tag;
    lookup_res_t          res;
    int                   way;
    int                   pos;
    bit                   found;
    line    = addr >> LINE_SHIFT;
    set_idx = SET_BITS'(line % NUM_SETS);
    tag     = TAG_BITS'(line / NUM_SETS);
    res     = '0;
    found   = 1'b0;
    way     = 0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (!found && line_valid[set_idx][w] && tag_mem[set_idx][w] == tag) begin
        found = 1'b1;
        way   = w;
      end
    end
    if (found) begin
      res.hit = 1'b1;
    end else begin
      for (int w = 0; w < NUM_WAYS; w++) begin
        if (!found && !line_valid[set_idx][w]) begin
          found = 1'b1;
          way   = w;
        end
      end
      if (!found) begin
        way         = lru_order[set_idx][0];
        res.evicted = 1'b1;
      end
      tag_mem[set_idx][way]    = tag;
      line_valid[set_idx][way] = 1'b1;
    end
    // move the way to the most-recent end
    pos = NUM_WAYS;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (pos == NUM_WAYS && lru_order[set_idx][w] == way) pos = w;
    end
    for (int i = pos; i < NUM_WAYS - 1; i++) lru_order[set_idx][i] = lru_order[set_idx][i + 1];
    lru_order[set_idx][NUM_WAYS - 1] = WAY_BITS'(way);
    res.way = WAY_FIELD_BITS'(way);
    return res;
  endfunction

  task automatic issue_address(input logic [ADDR_BITS-1:0] addr, input bit use_typed,
                               input lookup_res_t typed_res);
    int          gap;
    lookup_res_t predicted;
    gap = 0;
    if (!quiet_phase && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 3);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.address <= addr;
    do @(posedge clk); while (!in_bus.ready);
    predicted = lru_lookup(addr);
    pending_lookups.insert(pending_lookups.size(), use_typed ? typed_res : predicted);
  endtask

  // sender
  initial begin
    logic [TAG_BITS-1:0]  tag_pool [TAG_POOL];
    logic [ADDR_BITS-1:0] addr;
    lookup_res_t          typed_res;
    rst_n          <= 1'b0;
    in_bus.valid   <= 1'b0;
    in_bus.address <= '0;
    for (int s = 0; s < NUM_SETS; s++) begin
      for (int w = 0; w < NUM_WAYS; w++) begin
        line_valid[s][w] = 1'b0;
        tag_mem[s][w]    = '0;
        lru_order[s][w]  = WAY_BITS'(w);
      end
    end
    for (int i = 0; i < TAG_POOL; i++) tag_pool[i] = TAG_BITS'($urandom());
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DIR_ROWS; r++) begin
      typed_res = '{dir_rows[r].hit, dir_rows[r].way, dir_rows[r].evicted};
      issue_address(dir_rows[r].addr, dir_rows[r].typed, typed_res);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 300) long_hold_req = 1'b1;
      if (n == 700) begin
        // drain everything before going on
        in_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending_lookups.size() != 0) @(posedge clk);
      end
      if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet_phase = 1'b1;
      if ($urandom_range(0, 39) == 0) tag_pool[$urandom_range(0, TAG_POOL - 1)] = TAG_BITS'($urandom());
      // mostly a few tags per set so hits and LRU evictions are frequent
      if ($urandom_range(0, 99) < 15) addr = $urandom();
      else addr = {tag_pool[$urandom_range(0, TAG_POOL - 1)],
                   SET_BITS'($urandom_range(0, NUM_SETS - 1)),
                   LINE_SHIFT'($urandom_range(0, 15))};
      issue_address(addr, 1'b0, '0);
    end

    in_bus.valid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // receiver with random back-pressure and one long hold-off
  initial begin
    out_bus.ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_bus.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_bus.ready <= 1'b1;
      end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_bus.ready <= 1'b1;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    lookup_res_t exp_res;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_lookups.size() == 0) begin
        $display("%0t: unexpected result transaction hit=%0b way=%0d evicted=%0b",
                 $time, out_bus.hit, out_bus.way, out_bus.evicted);
        mismatch_count++;
      end else begin
        exp_res = pending_lookups.pop_front();
        if (out_bus.hit !== exp_res.hit) begin
          $display("%0t: hit mismatch, expected %0b actual %0b", $time, exp_res.hit, out_bus.hit);
          mismatch_count++;
        end
        if (out_bus.way !== exp_res.way) begin
          $display("%0t: way mismatch, expected %0d actual %0d", $time, exp_res.way, out_bus.way);
          mismatch_count++;
        end
        if (out_bus.evicted !== exp_res.evicted) begin
          $display("%0t: evicted mismatch, expected %0b actual %0b",
                   $time, exp_res.evicted, out_bus.evicted);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog: cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule
